// ----- hw/rtl/lias_pkg.sv -----
// ----------------------------------------------------------------------------
// lias_pkg
// Shared types, constants and the reference sine function for the lock-in
// amplitude statistics block.
// ----------------------------------------------------------------------------
package lias_pkg;

  // Field widths
  localparam int FREQ_W   = 20;
  localparam int RD_CNT_W = 11;
  localparam int SM_CNT_W = 13;
  localparam int RAW_W    = 16;
  localparam int TIME_W   = 24;
  localparam int AMP_W    = 19;
  localparam int V_W      = 19;
  localparam int PROD_W   = FREQ_W + TIME_W;
  localparam int MAC_W    = 35;
  localparam int SUM_W    = 48;
  localparam int ASUM_W   = 32;
  localparam int WIDE_W   = 64;
  localparam int DVS_W    = 32;

  // Count limits
  localparam int MAX_SAMPLES  = 4096;
  localparam int MAX_READINGS = 1024;

  // Reference table geometry
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int TAB_IDX_W        = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
  localparam int QTR_W            = $clog2(QTR_DEPTH);
  localparam int QTAB_W           = QTR_W + 1;

  // Phase arithmetic: one turn is a million parts
  localparam int PH_W       = 20;
  localparam int PHASE_MOD  = 1000000;
  localparam int COS_OFFSET = 250000;
  localparam int MOD_STEPS  = 4;   // estimate, subtract, two corrections
  localparam int IDX_STEPS  = 2;   // estimate, one correction
  localparam int EST_W      = 32;  // top bits of the product used for the estimate
  localparam int RECIP_W    = 25;
  // floor(2^44 / PHASE_MOD): quotient estimate never overshoots
  localparam logic [RECIP_W-1:0] PHASE_RECIP = 25'd17592186;

  localparam logic [AMP_W-1:0] AMP_MAX = '1;
  localparam longint Q30 = 64'sd1073741824;

  // Configuration register indexes
  localparam logic [1:0] CFG_FREQ     = 2'd0;
  localparam logic [1:0] CFG_READINGS = 2'd1;
  localparam logic [1:0] CFG_SAMPLES  = 2'd2;

  // Result kinds
  localparam logic KIND_AMP  = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  typedef struct packed {
    logic signed [V_W-1:0] v;
    logic [TAB_IDX_W-1:0]  sin_idx;
    logic [TAB_IDX_W-1:0]  cos_idx;
  } item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_MOD, F_PRE, F_IDX, F_PUSH
  } front_state_e;

  typedef enum logic [4:0] {
    B_IDLE, B_SIN, B_COS, B_ACC, B_DIV_I, B_DIV_Q, B_SQ_I, B_SQ_Q, B_SQ_ADD,
    B_SQRT_A, B_AMP_OUT, B_AMP_SQ, B_MEAN, B_SD_MUL_A, B_SD_MUL_B, B_SD_SUB,
    B_SD_DIV, B_SD_SQRT, B_STAT_OUT
  } back_state_e;

  // sin(pi/2 * u), u in Q30 over [0, 2^30], result Q14 (elaboration only)
  function automatic longint sine_q14(input longint u);
    longint u2;
    longint t;
    longint s;
    u2 = u * u / Q30;
    t  = 64'sd172272;
    t  = -64'sd5026995 + t * u2 / Q30;
    t  = 64'sd85569306 + t * u2 / Q30;
    t  = -64'sd693598670 + t * u2 / Q30;
    t  = 64'sd1686629713 + t * u2 / Q30;
    s  = t * u / Q30;
    if (s < 0) s = 0;
    if (s > Q30) s = Q30;
    return (s + 32768) / 65536;
  endfunction

endpackage

// ----- hw/rtl/lock_in_amplitude_statistics.sv -----
// ----------------------------------------------------------------------------
// lock_in_amplitude_statistics
// Lock-in I/Q demodulator: per-reading amplitude and per-measurement mean
// and sample standard deviation.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | raw_sample_i, sample_time_us_i
//   out     | out       | out_valid_o/out_ready_i | item_kind_o .. last_o
//
// The front takes one word at a time and works it through one product, a
// reciprocal estimate of the phase turns with two corrections, and two steps
// for the table indexes, then holds it until the queue has room. The back
// reads the table and accumulates each sample, runs two divides and a root at a
// reading end, and more at a measurement end. A two-word queue lets the front run ahead while
// the back works or the result word waits.
// Reset clears all sums and counts; config takes effect at once.
// ----------------------------------------------------------------------------
module lock_in_amplitude_statistics (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [lias_pkg::FREQ_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lias_pkg::RAW_W-1:0]        raw_sample_i,
  input  logic [lias_pkg::TIME_W-1:0]       sample_time_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              item_kind_o,
  output logic [lias_pkg::AMP_W-1:0]        amplitude_o,
  output logic [lias_pkg::AMP_W-1:0]        mean_amplitude_o,
  output logic [lias_pkg::AMP_W-1:0]        std_deviation_o,
  output logic                              last_o
);
  import lias_pkg::*;

  logic [FREQ_W-1:0]   freq_q;
  logic [RD_CNT_W-1:0] readings_q;
  logic [SM_CNT_W-1:0] samples_q;
  logic                q_valid, q_pop;
  item_t               q_item;

  // Config registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q     <= FREQ_W'(1000);
      readings_q <= RD_CNT_W'(10);
      samples_q  <= SM_CNT_W'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FREQ:     freq_q     <= cfg_data_i;
        CFG_READINGS: readings_q <= cfg_data_i[RD_CNT_W-1:0];
        CFG_SAMPLES:  samples_q  <= cfg_data_i[SM_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  lias_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .raw_sample_i     (raw_sample_i),
    .sample_time_us_i (sample_time_us_i),
    .freq_i           (freq_q),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  lias_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .samples_i        (samples_q),
    .readings_i       (readings_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .item_kind_o      (item_kind_o),
    .amplitude_o      (amplitude_o),
    .mean_amplitude_o (mean_amplitude_o),
    .std_deviation_o  (std_deviation_o),
    .last_o           (last_o)
  );

endmodule

// ----- hw/rtl/lias_front.sv -----
// ----------------------------------------------------------------------------
// lias_front
// Takes converter words, forms the signed voltage, works out the sine and
// cosine table indexes from the sample time and queues the result.
// ----------------------------------------------------------------------------
module lias_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lias_pkg::RAW_W-1:0]      raw_sample_i,
  input  logic [lias_pkg::TIME_W-1:0]     sample_time_us_i,
  input  logic [lias_pkg::FREQ_W-1:0]     freq_i,
  output logic                            q_valid_o,
  output lias_pkg::item_t                 q_item_o,
  input  logic                            q_pop_i
);
  import lias_pkg::*;

  localparam int QE_W  = EST_W + RECIP_W;
  localparam int CHK_W = PH_W + TAB_IDX_W;

  front_state_e state_q, state_d;

  logic signed [V_W-1:0] s_ext, v_calc, v_q;
  logic [TIME_W-1:0]     t_q;
  logic [PROD_W-1:0]     rem_q;
  logic [RECIP_W-1:0]    qe_q;
  logic [QE_W-1:0]       qe_prod;
  logic [4:0]            step_q;
  logic [PH_W:0]         rs_q, rc_q, rc_pre;
  logic [PROD_W-1:0]     is_prod, ic_prod;
  logic [CHK_W-1:0]      is_chk, ic_chk;
  logic                  is_up, ic_up;
  logic [TAB_IDX_W-1:0]  is_q, ic_q;

  item_t                 fifo_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;
  logic                  push, pop, accept;

  // Bits 15..1 are a two's complement code; volts in 2^-16 units = 10 * code
  assign s_ext  = {{(V_W - RAW_W + 1){raw_sample_i[RAW_W-1]}}, raw_sample_i[RAW_W-1:1]};
  assign v_calc = (s_ext <<< 3) + (s_ext <<< 1);

  // Quotient estimate of the phase product by one turn (low by at most two)
  assign qe_prod = QE_W'(rem_q[PROD_W-1:PROD_W-EST_W]) * QE_W'(PHASE_RECIP);
  assign rc_pre  = (PH_W+1)'(rem_q[PH_W-1:0]) + (PH_W+1)'(COS_OFFSET);

  // Table index estimates (low by at most one) and their check
  assign is_prod = PROD_W'(rs_q) * PROD_W'(PHASE_RECIP);
  assign ic_prod = PROD_W'(rc_q) * PROD_W'(PHASE_RECIP);
  assign is_chk  = {rs_q[PH_W-1:0], {TAB_IDX_W{1'b0}}} - (CHK_W'(is_q) * CHK_W'(PHASE_MOD));
  assign ic_chk  = {rc_q[PH_W-1:0], {TAB_IDX_W{1'b0}}} - (CHK_W'(ic_q) * CHK_W'(PHASE_MOD));
  assign is_up   = (is_chk >= CHK_W'(PHASE_MOD));
  assign ic_up   = (ic_chk >= CHK_W'(PHASE_MOD));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MUL;
      F_MUL:   state_d = F_MOD;
      F_MOD:   if (step_q == 5'(MOD_STEPS - 1)) state_d = F_PRE;
      F_PRE:   state_d = F_IDX;
      F_IDX:   if (step_q == 5'(IDX_STEPS - 1)) state_d = F_PUSH;
      F_PUSH:  if (cnt_q != 2'd2) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Handshake and queue control
  always_comb begin
    in_ready_o = (state_q == F_IDLE);
    accept     = in_ready_o && in_valid_i;
    push       = (state_q == F_PUSH) && (cnt_q != 2'd2);
    pop        = q_pop_i && (cnt_q != 2'd0);
    q_valid_o  = (cnt_q != 2'd0);
    q_item_o   = fifo_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      step_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
      if (state_q == F_MOD || state_q == F_IDX) begin
        step_q <= (state_d == state_q) ? step_q + 5'd1 : 5'd0;
      end else begin
        step_q <= 5'd0;
      end
    end
  end

  // Phase datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q <= v_calc;
      t_q <= sample_time_us_i;
    end
    case (state_q)
      F_MUL: begin
        rem_q <= {{TIME_W{1'b0}}, freq_i} * {{FREQ_W{1'b0}}, t_q};
      end
      F_MOD: begin
        // estimate, take off the estimated turns, then correct
        if (step_q == 5'd0) begin
          qe_q <= qe_prod[QE_W-1:EST_W];
        end else if (step_q == 5'd1) begin
          rem_q <= rem_q - (PROD_W'(qe_q) * PROD_W'(PHASE_MOD));
        end else if (rem_q >= PROD_W'(PHASE_MOD)) begin
          rem_q <= rem_q - PROD_W'(PHASE_MOD);
        end
      end
      F_PRE: begin
        rs_q <= (PH_W+1)'(rem_q[PH_W-1:0]);
        rc_q <= (rc_pre >= (PH_W+1)'(PHASE_MOD)) ? rc_pre - (PH_W+1)'(PHASE_MOD) : rc_pre;
      end
      F_IDX: begin
        if (step_q == 5'd0) begin
          is_q <= is_prod[PROD_W-1:PROD_W-TAB_IDX_W];
          ic_q <= ic_prod[PROD_W-1:PROD_W-TAB_IDX_W];
        end else begin
          is_q <= is_q + TAB_IDX_W'(is_up);
          ic_q <= ic_q + TAB_IDX_W'(ic_up);
        end
      end
      default: ;
    endcase
    if (push) begin
      fifo_q[wr_ptr_q].v       <= v_q;
      fifo_q[wr_ptr_q].sin_idx <= is_q;
      fifo_q[wr_ptr_q].cos_idx <= ic_q;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("front queue count out of range");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_PUSH && cnt_q == 2'd2 && !q_pop_i) |=> state_q == F_PUSH)
    else $error("front pushed into a full queue");

endmodule

// ----- hw/rtl/lias_div.sv -----
// ----------------------------------------------------------------------------
// lias_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lias_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lias_pkg::WIDE_W-1:0]  dividend_i,
  input  logic [lias_pkg::DVS_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [lias_pkg::WIDE_W-1:0]  quotient_o
);
  import lias_pkg::*;

  logic                  busy_q, done_q;
  logic [5:0]            step_q;
  logic [WIDE_W-1:0]     quo_q;
  logic [DVS_W-1:0]      dvs_q;
  logic [DVS_W:0]        rem_q, rem_sh;
  logic                  fits;

  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[WIDE_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 6'd0;
      end else if (busy_q) begin
        step_q <= step_q + 6'd1;
        if (step_q == 6'(WIDE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_q <= {quo_q[WIDE_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/lias_sqrt.sv -----
// ----------------------------------------------------------------------------
// lias_sqrt
// Integer square root of a 64-bit word, one result bit per cycle, with the
// remainder x - r*r.
// ----------------------------------------------------------------------------
module lias_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lias_pkg::WIDE_W-1:0]  x_i,
  output logic                         done_o,
  output logic [31:0]                  root_o,
  output logic [32:0]                  rem_o
);
  import lias_pkg::*;

  logic              busy_q, done_q;
  logic [4:0]        step_q;
  logic [WIDE_W-1:0] x_q, r_q, b_q, trial;
  logic              fits;

  assign trial = r_q + b_q;
  assign fits  = (x_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 5'd0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Digit-by-digit root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      r_q <= '0;
      b_q <= WIDE_W'(1) << (WIDE_W - 2);
    end else if (busy_q) begin
      if (fits) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];
  assign rem_o  = x_q[32:0];

endmodule

// ----- hw/rtl/lias_back.sv -----
// ----------------------------------------------------------------------------
// lias_back
// Multiply-accumulate against the reference table, reading amplitudes and
// measurement statistics, and the result register.
// ----------------------------------------------------------------------------
module lias_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  lias_pkg::item_t                   q_item_i,
  output logic                              q_pop_o,
  input  logic [lias_pkg::SM_CNT_W-1:0]     samples_i,
  input  logic [lias_pkg::RD_CNT_W-1:0]     readings_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              item_kind_o,
  output logic [lias_pkg::AMP_W-1:0]        amplitude_o,
  output logic [lias_pkg::AMP_W-1:0]        mean_amplitude_o,
  output logic [lias_pkg::AMP_W-1:0]        std_deviation_o,
  output logic                              last_o
);
  import lias_pkg::*;

  back_state_e state_q, state_d;

  // Quarter-wave table, built at elaboration
  logic signed [15:0] qtab [QTR_DEPTH+1];
  for (genvar g = 0; g <= QTR_DEPTH; g++) begin : g_qtab
    assign qtab[g] = 16'(sine_q14(longint'(g) << (30 - QTR_W)));
  end

  item_t                  item_q;
  logic signed [MAC_W-1:0] prod_q;
  logic signed [SUM_W-1:0] i_sum_q, q_sum_q, sel_sum;
  logic [SUM_W-1:0]       abs_sum;
  logic [SM_CNT_W-1:0]    cnt_q, cnt_inc, s_target;
  logic [RD_CNT_W-1:0]    rc_q, rc_inc, r_target;
  logic [ASUM_W-1:0]      sum_a_q;
  logic [SUM_W-1:0]       sum_sq_q;
  logic [31:0]            mi_q, mq_q;
  logic [WIDE_W-1:0]      m1_q, m2_q, sq_in_q;
  logic [DVS_W-1:0]       dd_q;
  logic [AMP_W-1:0]       amp_q, mean_q, sd_q;

  logic [TAB_IDX_W-1:0]   tab_idx;
  logic [QTAB_W-1:0]      qi;
  logic signed [15:0]     tab_mag, tab_val;

  logic                   run_q, div_state, sqrt_state, div_start, sqrt_start;
  logic                   div_done, sqrt_done;
  logic [WIDE_W-1:0]      div_dividend, div_quo;
  logic [DVS_W-1:0]       div_divisor;
  logic [31:0]            sq_root;
  logic [32:0]            sq_rem;
  logic [AMP_W:0]         amp_raw;
  logic [AMP_W-1:0]       amp_sat, mean_sat, sd_sat;
  logic [32:0]            sd_round;

  logic                   out_valid_q, kind_q, last_q, out_free, out_wr;
  logic [AMP_W-1:0]       out_amp_q, out_mean_q, out_sd_q;

  // Counts: zero acts as one, large values saturate
  assign s_target = (samples_i == '0) ? SM_CNT_W'(1) :
                    (samples_i > SM_CNT_W'(MAX_SAMPLES)) ? SM_CNT_W'(MAX_SAMPLES) : samples_i;
  assign r_target = (readings_i == '0) ? RD_CNT_W'(1) :
                    (readings_i > RD_CNT_W'(MAX_READINGS)) ? RD_CNT_W'(MAX_READINGS) : readings_i;
  assign cnt_inc  = cnt_q + SM_CNT_W'(1);
  assign rc_inc   = rc_q + RD_CNT_W'(1);

  // Table lookup with quadrant mirroring
  always_comb begin
    tab_idx = (state_q == B_SIN) ? item_q.sin_idx : item_q.cos_idx;
    qi      = tab_idx[TAB_IDX_W-2] ? QTAB_W'(QTR_DEPTH) - {1'b0, tab_idx[QTR_W-1:0]}
                                   : {1'b0, tab_idx[QTR_W-1:0]};
    tab_mag = qtab[qi];
    tab_val = tab_idx[TAB_IDX_W-1] ? -tab_mag : tab_mag;
  end

  // Divider and root operands
  always_comb begin
    sel_sum      = (state_q == B_DIV_Q) ? q_sum_q : i_sum_q;
    abs_sum      = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
    div_state    = (state_q == B_DIV_I) || (state_q == B_DIV_Q) ||
                   (state_q == B_MEAN) || (state_q == B_SD_DIV);
    sqrt_state   = (state_q == B_SQRT_A) || (state_q == B_SD_SQRT);
    div_start    = div_state && !run_q;
    sqrt_start   = sqrt_state && !run_q;
    div_dividend = sq_in_q;
    div_divisor  = dd_q;
    case (state_q)
      B_DIV_I, B_DIV_Q: begin
        div_dividend = WIDE_W'(abs_sum) + WIDE_W'(cnt_q >> 1);
        div_divisor  = DVS_W'(cnt_q);
      end
      B_MEAN: begin
        div_dividend = WIDE_W'(sum_a_q) + WIDE_W'(rc_q >> 1);
        div_divisor  = DVS_W'(rc_q);
      end
      default: ;
    endcase
  end

  // Rounding and saturation of results
  always_comb begin
    amp_raw  = (AMP_W+1)'((33'(sq_root) + 33'd4096) >> 13);
    amp_sat  = amp_raw[AMP_W] ? AMP_MAX : amp_raw[AMP_W-1:0];
    mean_sat = (div_quo > WIDE_W'(AMP_MAX)) ? AMP_MAX : div_quo[AMP_W-1:0];
    sd_round = 33'(sq_root) + ((sq_rem > 33'(sq_root)) ? 33'd1 : 33'd0);
    sd_sat   = (sd_round > 33'(AMP_MAX)) ? AMP_MAX : sd_round[AMP_W-1:0];
  end

  lias_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  lias_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sq_in_q),
    .done_o  (sqrt_done),
    .root_o  (sq_root),
    .rem_o   (sq_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:     if (q_valid_i) state_d = B_SIN;
      B_SIN:      state_d = B_COS;
      B_COS:      state_d = B_ACC;
      B_ACC:      state_d = (cnt_inc >= s_target) ? B_DIV_I : B_IDLE;
      B_DIV_I:    if (div_done) state_d = B_DIV_Q;
      B_DIV_Q:    if (div_done) state_d = B_SQ_I;
      B_SQ_I:     state_d = B_SQ_Q;
      B_SQ_Q:     state_d = B_SQ_ADD;
      B_SQ_ADD:   state_d = B_SQRT_A;
      B_SQRT_A:   if (sqrt_done) state_d = B_AMP_OUT;
      B_AMP_OUT:  if (out_free) state_d = B_AMP_SQ;
      B_AMP_SQ:   state_d = (rc_q >= r_target) ? B_MEAN : B_IDLE;
      B_MEAN:     if (div_done) state_d = (rc_q == RD_CNT_W'(1)) ? B_STAT_OUT : B_SD_MUL_A;
      B_SD_MUL_A: state_d = B_SD_MUL_B;
      B_SD_MUL_B: state_d = B_SD_SUB;
      B_SD_SUB:   state_d = B_SD_DIV;
      B_SD_DIV:   if (div_done) state_d = B_SD_SQRT;
      B_SD_SQRT:  if (sqrt_done) state_d = B_STAT_OUT;
      B_STAT_OUT: if (out_free) state_d = B_IDLE;
      default:    state_d = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop_o  = (state_q == B_IDLE) && q_valid_i;
    out_free = !out_valid_q || out_ready_i;
    out_wr   = ((state_q == B_AMP_OUT) || (state_q == B_STAT_OUT)) && out_free;
  end

  // Control state and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      i_sum_q     <= '0;
      q_sum_q     <= '0;
      cnt_q       <= '0;
      rc_q        <= '0;
      sum_a_q     <= '0;
      sum_sq_q    <= '0;
    end else begin
      state_q <= state_d;
      if (div_start || sqrt_start)    run_q <= 1'b1;
      else if (div_done || sqrt_done) run_q <= 1'b0;
      if (out_wr)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        B_COS: i_sum_q <= i_sum_q + SUM_W'(prod_q);
        B_ACC: begin
          q_sum_q <= q_sum_q + SUM_W'(prod_q);
          cnt_q   <= cnt_inc;
        end
        B_AMP_OUT: if (out_free) begin
          sum_a_q <= sum_a_q + ASUM_W'(amp_q);
          rc_q    <= rc_inc;
          i_sum_q <= '0;
          q_sum_q <= '0;
          cnt_q   <= '0;
        end
        B_AMP_SQ: sum_sq_q <= sum_sq_q + m1_q[SUM_W-1:0];
        B_STAT_OUT: if (out_free) begin
          rc_q     <= '0;
          sum_a_q  <= '0;
          sum_sq_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Arithmetic datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE:     if (q_valid_i) item_q <= q_item_i;
      B_SIN,
      B_COS:      prod_q <= MAC_W'(item_q.v) * MAC_W'(tab_val);
      B_DIV_I:    if (div_done) mi_q <= div_quo[31:0];
      B_DIV_Q:    if (div_done) mq_q <= div_quo[31:0];
      B_SQ_I:     m1_q <= {32'd0, mi_q} * {32'd0, mq_q ^ mq_q ^ mi_q};
      B_SQ_Q:     m2_q <= {32'd0, mq_q} * {32'd0, mq_q};
      B_SQ_ADD:   sq_in_q <= m1_q + m2_q;
      B_SQRT_A:   if (sqrt_done) amp_q <= amp_sat;
      B_AMP_OUT:  m1_q <= WIDE_W'(amp_q) * WIDE_W'(amp_q);
      B_MEAN: if (div_done) begin
        mean_q <= mean_sat;
        sd_q   <= '0;
      end
      B_SD_MUL_A: m1_q <= WIDE_W'(rc_q) * WIDE_W'(sum_sq_q);
      B_SD_MUL_B: begin
        m2_q <= {32'd0, sum_a_q} * {32'd0, sum_a_q};
        dd_q <= DVS_W'(rc_q) * DVS_W'(rc_q - RD_CNT_W'(1));
      end
      B_SD_SUB:   sq_in_q <= (m1_q > m2_q) ? m1_q - m2_q : '0;
      B_SD_DIV:   if (div_done) sq_in_q <= div_quo;
      B_SD_SQRT:  if (sqrt_done) sd_q <= sd_sat;
      default: ;
    endcase
    // Result word register
    if (out_wr) begin
      if (state_q == B_AMP_OUT) begin
        kind_q     <= KIND_AMP;
        out_amp_q  <= amp_q;
        out_mean_q <= '0;
        out_sd_q   <= '0;
        last_q     <= 1'b0;
      end else begin
        kind_q     <= KIND_STAT;
        out_amp_q  <= '0;
        out_mean_q <= mean_q;
        out_sd_q   <= sd_q;
        last_q     <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = kind_q;
  assign amplitude_o      = out_amp_q;
  assign mean_amplitude_o = out_mean_q;
  assign std_deviation_o  = out_sd_q;
  assign last_o           = last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == B_DIV_I || state_q == B_DIV_Q ||
                  state_q == B_MEAN || state_q == B_SD_DIV))
    else $error("divider finished outside a divide step");
  a_stat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_STAT_OUT) |-> (rc_q != '0))
    else $error("statistics emitted with no readings");

endmodule
